// ===== src/bde_pkg.sv =====
`default_nettype none

package bde_pkg;

    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ACT_PUSH_BACK  = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_CLEAR      = 3'd4,
        ACT_REMOVE     = 3'd5,
        ACT_READ_LAST  = 3'd6,
        ACT_REVERSE    = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        action_t            action;
        logic signed [31:0] value;
        logic [6:0]         position;
    } req_item_t;

    typedef struct packed {
        logic [6:0]         entry_count;
        logic signed [31:0] read_value;
        status_t            status;
    } rsp_item_t;

    typedef struct packed {
        logic                 we;
        logic                 wbank;
        logic [ADDR_W-1:0]    waddr;
        logic [WORD_BITS-1:0] wdata;
        logic                 re;
        logic                 rbank;
        logic [ADDR_W-1:0]    raddr;
    } mem_req_t;

endpackage

`default_nettype wire

// ===== src/bde_store.sv =====
`default_nettype none

module bde_store (
    input  wire logic                          clk,
    input  wire bde_pkg::mem_req_t             mreq,
    output logic [bde_pkg::WORD_BITS-1:0]      rdata
);
    import bde_pkg::*;

    logic [WORD_BITS-1:0] bank0 [DEPTH];
    logic [WORD_BITS-1:0] bank1 [DEPTH];
    logic [WORD_BITS-1:0] rdata0_reg;
    logic [WORD_BITS-1:0] rdata1_reg;
    logic                 rsel_reg;

    always_ff @(posedge clk)
    begin
        if (mreq.we && !mreq.wbank)
        begin
            bank0[mreq.waddr] <= mreq.wdata;
        end
        if (mreq.re)
        begin
            rdata0_reg <= bank0[mreq.raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mreq.we && mreq.wbank)
        begin
            bank1[mreq.waddr] <= mreq.wdata;
        end
        if (mreq.re)
        begin
            rdata1_reg <= bank1[mreq.raddr];
            rsel_reg   <= mreq.rbank;
        end
    end

    assign rdata = rsel_reg ? rdata1_reg : rdata0_reg;

endmodule

`default_nettype wire

// ===== src/bounded_deque_engine_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_ready   bde_pkg::req_item_t
// rsp       out        rsp_valid/rsp_ready   bde_pkg::rsp_item_t
//
// Push, pop, clear and reverse are done in the idle state, with no store read.
// A read counted back from the last entry waits in S_READ for the store's registered read.
// Remove matching issues one store read per entry and writes survivors to the other bank.
// Reset clears the pointers, count and flags; the store itself is not cleared.
// A result waiting on rsp_ready holds off the next request transaction.

module bounded_deque_engine_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire bde_pkg::req_item_t  req,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output bde_pkg::rsp_item_t       rsp
);
    import bde_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_READ   = 3'b010,
        S_REMOVE = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    front_reg, front_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 rev_reg, rev_next;
    logic                 bank_reg, bank_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic [CNT_W-1:0]     iss_reg, iss_next;
    logic [CNT_W-1:0]     keep_reg, keep_next;
    logic                 rv_reg, rv_next;
    logic                 out_valid_reg, out_valid_next;
    rsp_item_t            out_reg, out_next;

    mem_req_t             mreq;
    logic [WORD_BITS-1:0] rdata;
    logic                 out_free;
    logic                 accept;
    logic                 to_run_end;
    logic                 from_run_start;
    logic [CNT_W-1:0]     last_idx;
    logic [CNT_W-1:0]     rd_off;
    logic [CNT_W-1:0]     rm_off;

    bde_store u_store (
        .clk   (clk),
        .mreq  (mreq),
        .rdata (rdata)
    );

    assign out_free       = !out_valid_reg || rsp_ready;
    assign req_ready      = (state_reg == S_IDLE) && out_free;
    assign accept         = req_valid && req_ready;
    assign rsp_valid      = out_valid_reg;
    assign rsp            = out_reg;
    assign to_run_end     = (req.action == ACT_PUSH_BACK) != rev_reg;
    assign from_run_start = (req.action == ACT_POP_FRONT) != rev_reg;
    assign last_idx       = count_reg - CNT_W'(1);
    assign rd_off         = rev_reg ? req.position[CNT_W-1:0]
                                    : last_idx - req.position[CNT_W-1:0];
    assign rm_off         = rev_reg ? last_idx - iss_reg : iss_reg;

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        rev_next       = rev_reg;
        bank_next      = bank_reg;
        word_next      = word_reg;
        iss_next       = iss_reg;
        keep_next      = keep_reg;
        rv_next        = 1'b0;
        out_valid_next = out_valid_reg && !rsp_ready;
        out_next       = out_reg;
        mreq           = '0;
        mreq.wbank     = bank_reg;
        mreq.rbank     = bank_reg;
        mreq.wdata     = req.value;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_next.read_value = '0;
                    out_next.status     = ST_OK;
                    out_valid_next      = 1'b1;
                    case (req.action)
                        ACT_PUSH_BACK, ACT_PUSH_FRONT:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                out_next.status = ST_FULL;
                            end
                            else
                            begin
                                mreq.we    = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                if (to_run_end)
                                begin
                                    mreq.waddr = front_reg + count_reg[ADDR_W-1:0];
                                end
                                else
                                begin
                                    front_next = front_reg - ADDR_W'(1);
                                    mreq.waddr = front_reg - ADDR_W'(1);
                                end
                            end
                        end
                        ACT_POP_FRONT, ACT_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                out_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                                if (from_run_start)
                                begin
                                    front_next = front_reg + ADDR_W'(1);
                                end
                            end
                        end
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                            front_next = '0;
                            rev_next   = 1'b0;
                        end
                        ACT_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                out_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                out_valid_next = out_valid_reg && !rsp_ready;
                                word_next      = req.value;
                                iss_next       = '0;
                                keep_next      = '0;
                                state_next     = S_REMOVE;
                            end
                        end
                        ACT_READ_LAST:
                        begin
                            if ({1'b0, req.position} >= {1'b0, count_reg})
                            begin
                                out_next.status = ST_RANGE;
                            end
                            else
                            begin
                                out_valid_next = out_valid_reg && !rsp_ready;
                                mreq.re        = 1'b1;
                                mreq.raddr     = front_reg + rd_off[ADDR_W-1:0];
                                state_next     = S_READ;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                out_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                rev_next = !rev_reg;
                            end
                        end
                    endcase
                    out_next.entry_count = count_next;
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    out_next.entry_count = count_reg;
                    out_next.read_value  = rdata;
                    out_next.status      = ST_OK;
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            S_REMOVE:
            begin
                if (iss_reg != count_reg)
                begin
                    mreq.re    = 1'b1;
                    mreq.raddr = front_reg + rm_off[ADDR_W-1:0];
                    iss_next   = iss_reg + CNT_W'(1);
                    rv_next    = 1'b1;
                end
                // Survivors go to the other bank, packed from slot 0.
                if (rv_reg && (rdata != word_reg))
                begin
                    mreq.we    = 1'b1;
                    mreq.wbank = !bank_reg;
                    mreq.waddr = keep_reg[ADDR_W-1:0];
                    mreq.wdata = rdata;
                    keep_next  = keep_reg + CNT_W'(1);
                end
                if ((iss_reg == count_reg) && !rv_reg && out_free)
                begin
                    count_next           = keep_reg;
                    front_next           = '0;
                    rev_next             = 1'b0;
                    bank_next            = !bank_reg;
                    out_next.entry_count = keep_reg;
                    out_next.read_value  = '0;
                    out_next.status      = ST_OK;
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            bank_reg      <= 1'b0;
            iss_reg       <= '0;
            keep_reg      <= '0;
            rv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            rev_reg       <= rev_next;
            bank_reg      <= bank_next;
            iss_reg       <= iss_next;
            keep_reg      <= keep_next;
            rv_reg        <= rv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        out_reg  <= out_next;
    end

endmodule

`default_nettype wire
